/* hw/rtl/azls_pkg.sv */
package azls_pkg;

  localparam int SampleW   = 10;
  localparam int BounceW   = 16;
  localparam int ZoneIdxW  = 4;
  localparam int AreaOutW  = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int MaskW     = 16;
  // area a owns bits a*ZoneStride +: zones of the membership word
  localparam int ZoneStride = 16;

  localparam int DefZones = 16;
  localparam int DefAreas = 4;

  localparam logic [BounceW-1:0] BounceReloadRst = BounceW'(1);

  typedef enum logic [1:0] {
    EvNothing = 2'd0,
    EvNormal  = 2'd1,
    EvTrigger = 2'd2,
    EvTamper  = 2'd3
  } zone_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNormalLevel  = 3'd0,
    CfgTriggerLevel = 3'd1,
    CfgTolerance    = 3'd2,
    CfgBounceReload = 3'd3,
    CfgOpenMask     = 3'd4,
    CfgSkipMask     = 3'd5,
    CfgAreaMap      = 3'd6
  } cfg_reg_e;

  // control from the evaluation logic to the state holder
  typedef struct packed {
    zone_event_e        ev;
    logic               cnt_we;
    logic [BounceW-1:0] cnt_d;
  } azls_ctl_t;

  // one result item
  typedef struct packed {
    zone_event_e         ev;
    logic [ZoneIdxW-1:0] zone;
    logic [SampleW-1:0]  reading;
    logic [AreaOutW-1:0] area_trig;
    logic [AreaOutW-1:0] area_tamp;
  } azls_res_t;

endpackage

/* hw/rtl/azls_zone_eval.sv */
module azls_zone_eval #(
  parameter int ZONES = azls_pkg::DefZones,
  parameter int AREAS = azls_pkg::DefAreas
) (
  input  logic                              active_i,
  input  logic [ZONES-1:0]                  zone_bit_i,
  input  logic                              open_i,
  input  logic [azls_pkg::SampleW-1:0]      sample_i,
  input  logic [azls_pkg::SampleW-1:0]      normal_level_i,
  input  logic [azls_pkg::SampleW-1:0]      trigger_level_i,
  input  logic [azls_pkg::SampleW-1:0]      tolerance_i,
  input  logic [azls_pkg::BounceW-1:0]      bounce_reload_i,
  input  logic [azls_pkg::BounceW-1:0]      cnt_i,
  input  logic [AREAS-1:0][ZONES-1:0]       area_map_i,
  input  logic [ZONES-1:0]                  zone_trig_i,
  input  logic [ZONES-1:0]                  zone_tamp_i,
  input  logic [AREAS-1:0]                  area_trig_i,
  input  logic [AREAS-1:0]                  area_tamp_i,
  output logic [ZONES-1:0]                  zone_trig_o,
  output logic [ZONES-1:0]                  zone_tamp_o,
  output logic [AREAS-1:0]                  area_trig_o,
  output logic [AREAS-1:0]                  area_tamp_o,
  output azls_pkg::azls_ctl_t               ctl_o
);

  localparam int SW = azls_pkg::SampleW;
  localparam int BW = azls_pkg::BounceW;

  function automatic logic in_win(logic [SW-1:0] v, logic [SW-1:0] c, logic [SW-1:0] t);
    logic [SW-1:0] lo;
    logic [SW:0]   sum;
    logic [SW-1:0] hi;
    lo  = (c > t) ? (c - t) : '0;
    sum = {1'b0, c} + {1'b0, t};
    hi  = sum[SW] ? '1 : sum[SW-1:0];
    return (v >= lo) && (v <= hi);
  endfunction

  azls_pkg::zone_event_e cur, prev;
  logic [AREAS-1:0] member, clr_trig, clr_tamp;

  always_comb begin
    if (in_win(sample_i, normal_level_i, tolerance_i)) begin
      cur = open_i ? azls_pkg::EvTrigger : azls_pkg::EvNormal;
    end else if (in_win(sample_i, trigger_level_i, tolerance_i)) begin
      cur = open_i ? azls_pkg::EvNormal : azls_pkg::EvTrigger;
    end else begin
      cur = azls_pkg::EvTamper;
    end

    if (|(zone_tamp_i & zone_bit_i)) begin
      prev = azls_pkg::EvTamper;
    end else if (|(zone_trig_i & zone_bit_i)) begin
      prev = azls_pkg::EvTrigger;
    end else begin
      prev = azls_pkg::EvNormal;
    end
  end

  // an area flag may drop only if no other member zone still holds it
  always_comb begin
    for (int a = 0; a < AREAS; a++) begin
      member[a]   = |(area_map_i[a] & zone_bit_i);
      clr_trig[a] = member[a] & ~|(area_map_i[a] & zone_trig_i & ~zone_bit_i);
      clr_tamp[a] = member[a] & ~|(area_map_i[a] & zone_tamp_i & ~zone_bit_i);
    end
  end

  always_comb begin
    zone_trig_o  = zone_trig_i;
    zone_tamp_o  = zone_tamp_i;
    area_trig_o  = area_trig_i;
    area_tamp_o  = area_tamp_i;
    ctl_o.ev     = azls_pkg::EvNothing;
    ctl_o.cnt_we = 1'b0;
    ctl_o.cnt_d  = '0;

    if (!active_i) begin
      ctl_o.ev = azls_pkg::EvNothing;
    end else if ((prev == cur) && (cnt_i == '0)) begin
      ctl_o.ev = azls_pkg::EvNothing;
    end else if (cur == azls_pkg::EvTamper) begin
      zone_tamp_o  = zone_tamp_i | zone_bit_i;
      area_tamp_o  = area_tamp_i | member;
      ctl_o.cnt_we = 1'b1;
      ctl_o.ev     = azls_pkg::EvTamper;
    end else if (prev == azls_pkg::EvTamper) begin
      // back from tamper: area triggered flags are left alone
      zone_tamp_o  = zone_tamp_i & ~zone_bit_i;
      zone_trig_o  = zone_trig_i & ~zone_bit_i;
      area_tamp_o  = area_tamp_i & ~clr_tamp;
      ctl_o.cnt_we = 1'b1;
      ctl_o.ev     = azls_pkg::EvNormal;
    end else if (cnt_i > BW'(1)) begin
      ctl_o.cnt_we = 1'b1;
      ctl_o.cnt_d  = (cur == azls_pkg::EvTrigger) ? '0 : (cnt_i - BW'(1));
    end else if (cnt_i == BW'(1)) begin
      ctl_o.cnt_we = 1'b1;
      if (cur != azls_pkg::EvTrigger) begin
        zone_trig_o = zone_trig_i & ~zone_bit_i;
        zone_tamp_o = zone_tamp_i & ~zone_bit_i;
        area_trig_o = area_trig_i & ~clr_trig;
        ctl_o.ev    = azls_pkg::EvNormal;
      end
    end else if (cur == azls_pkg::EvNormal) begin
      // first return to normal starts the countdown
      ctl_o.cnt_we = 1'b1;
      ctl_o.cnt_d  = (bounce_reload_i == '0) ? BW'(1) : bounce_reload_i;
    end else begin
      zone_trig_o  = zone_trig_i | zone_bit_i;
      area_trig_o  = area_trig_i | member;
      ctl_o.cnt_we = 1'b1;
      ctl_o.ev     = azls_pkg::EvTrigger;
    end
  end

endmodule

/* hw/rtl/alarm_zone_loop_supervisor.sv */
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | zone_index_i, sample_i
// out     | output    | out_valid_o / out_stall_i  | zone_event_o, event_zone_o, reading_o,
//         |           |                            | areas_triggered_o, areas_tampered_o
// cfg     | input     | cfg_we_i                   | cfg_addr_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; a transfer lands in the output register at
// its accepting edge when that register is empty or draining, otherwise in the skid entry
// until the output drains. Classification, debounce and area updates are one combinational
// pass from the input ports into the zone state and the result register.
// A two-entry output buffer (result register plus skid) lets input be taken while a
// result waits; in_stall_o rises only when both entries are full.
// rst_ni clears all flags and countdowns and loads the register reset values.
module alarm_zone_loop_supervisor #(
  parameter int ZONES = azls_pkg::DefZones,
  parameter int AREAS = azls_pkg::DefAreas
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [azls_pkg::CfgIdxW-1:0]        cfg_addr_i,
  input  logic [azls_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [azls_pkg::ZoneIdxW-1:0]       zone_index_i,
  input  logic [azls_pkg::SampleW-1:0]        sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          zone_event_o,
  output logic [azls_pkg::ZoneIdxW-1:0]       event_zone_o,
  output logic [azls_pkg::SampleW-1:0]        reading_o,
  output logic [azls_pkg::AreaOutW-1:0]       areas_triggered_o,
  output logic [azls_pkg::AreaOutW-1:0]       areas_tampered_o
);

  localparam int SW = azls_pkg::SampleW;
  localparam int BW = azls_pkg::BounceW;
  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;

  // configuration
  logic [SW-1:0]            normal_level_q, trigger_level_q, tolerance_q;
  logic [BW-1:0]            bounce_reload_q;
  logic [ZONES-1:0]         open_mask_q, skip_mask_q;
  logic [AREAS-1:0][ZONES-1:0] area_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_level_q  <= '0;
      trigger_level_q <= '0;
      tolerance_q     <= '0;
      bounce_reload_q <= azls_pkg::BounceReloadRst;
      open_mask_q     <= '0;
      skip_mask_q     <= '0;
      area_map_q      <= '0;
    end else if (cfg_we_i) begin
      case (azls_pkg::cfg_reg_e'(cfg_addr_i))
        azls_pkg::CfgNormalLevel:  normal_level_q  <= cfg_data_i[SW-1:0];
        azls_pkg::CfgTriggerLevel: trigger_level_q <= cfg_data_i[SW-1:0];
        azls_pkg::CfgTolerance:    tolerance_q     <= cfg_data_i[SW-1:0];
        azls_pkg::CfgBounceReload: bounce_reload_q <= cfg_data_i[BW-1:0];
        azls_pkg::CfgOpenMask:     open_mask_q     <= cfg_data_i[ZONES-1:0];
        azls_pkg::CfgSkipMask:     skip_mask_q     <= cfg_data_i[ZONES-1:0];
        azls_pkg::CfgAreaMap: begin
          for (int a = 0; a < AREAS; a++) begin
            area_map_q[a] <= cfg_data_i[a*azls_pkg::ZoneStride +: ZONES];
          end
        end
        default: ;
      endcase
    end
  end

  // zone state
  logic [ZONES-1:0] zone_trig_q, zone_tamp_q, zone_trig_d, zone_tamp_d;
  logic [AREAS-1:0] area_trig_q, area_tamp_q, area_trig_d, area_tamp_d;
  logic [BW-1:0]    bounce_q [ZONES];

  logic             accept, pop, in_range, active;
  logic [ZW-1:0]    zi;
  logic [ZONES-1:0] zone_bit;
  azls_pkg::azls_ctl_t ctl;

  assign accept   = in_valid_i && !in_stall_o;
  assign zi       = zone_index_i[ZW-1:0];
  assign in_range = ({1'b0, zone_index_i} < (azls_pkg::ZoneIdxW + 1)'(ZONES));
  assign active   = in_range && !skip_mask_q[zi];

  always_comb begin
    zone_bit     = '0;
    zone_bit[zi] = in_range;
  end

  azls_zone_eval #(
    .ZONES(ZONES),
    .AREAS(AREAS)
  ) u_eval (
    .active_i       (active),
    .zone_bit_i     (zone_bit),
    .open_i         (open_mask_q[zi]),
    .sample_i       (sample_i),
    .normal_level_i (normal_level_q),
    .trigger_level_i(trigger_level_q),
    .tolerance_i    (tolerance_q),
    .bounce_reload_i(bounce_reload_q),
    .cnt_i          (bounce_q[zi]),
    .area_map_i     (area_map_q),
    .zone_trig_i    (zone_trig_q),
    .zone_tamp_i    (zone_tamp_q),
    .area_trig_i    (area_trig_q),
    .area_tamp_i    (area_tamp_q),
    .zone_trig_o    (zone_trig_d),
    .zone_tamp_o    (zone_tamp_d),
    .area_trig_o    (area_trig_d),
    .area_tamp_o    (area_tamp_d),
    .ctl_o          (ctl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_trig_q <= '0;
      zone_tamp_q <= '0;
      area_trig_q <= '0;
      area_tamp_q <= '0;
      for (int i = 0; i < ZONES; i++) begin
        bounce_q[i] <= '0;
      end
    end else if (accept) begin
      zone_trig_q <= zone_trig_d;
      zone_tamp_q <= zone_tamp_d;
      area_trig_q <= area_trig_d;
      area_tamp_q <= area_tamp_d;
      if (active && ctl.cnt_we) begin
        bounce_q[zi] <= ctl.cnt_d;
      end
    end
  end

  // output buffer: result register plus skid entry
  azls_pkg::azls_res_t res_new, out_q, skid_q;
  logic out_valid_q, skid_valid_q;

  assign res_new.ev        = ctl.ev;
  assign res_new.zone      = zone_index_i;
  assign res_new.reading   = sample_i;
  assign res_new.area_trig = azls_pkg::AreaOutW'(area_trig_d);
  assign res_new.area_tamp = azls_pkg::AreaOutW'(area_tamp_d);

  assign pop        = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || pop) begin
        out_valid_q  <= skid_valid_q || accept;
        skid_valid_q <= 1'b0;
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (accept) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign zone_event_o      = out_q.ev;
  assign event_zone_o      = out_q.zone;
  assign reading_o         = out_q.reading;
  assign areas_triggered_o = out_q.area_trig;
  assign areas_tampered_o  = out_q.area_tamp;

  // skid entry is only ever filled behind a full result register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty result register");

  // a transfer into an empty buffer shows up at the output next cycle
  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !out_valid_q) |=> (out_valid_o && (event_zone_o == $past(zone_index_i))
                                  && (reading_o == $past(sample_i))))
    else $error("accepted item missing from result register");

  // a skipped zone leaves every flag untouched and reports nothing
  a_skip_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !active) |=> ((zone_trig_q == $past(zone_trig_q))
                             && (zone_tamp_q == $past(zone_tamp_q))
                             && (area_trig_q == $past(area_trig_q))
                             && (area_tamp_q == $past(area_tamp_q))))
    else $error("skipped zone changed supervisor state");

  a_skip_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active |-> (ctl.ev == azls_pkg::EvNothing) && !ctl.cnt_we)
    else $error("event raised for skipped zone");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import azls_pkg::*;

  typedef struct {
    logic [ZoneIdxW-1:0] zone;
    logic [SampleW-1:0]  smp;
  } loop_sample_t;

  typedef enum int {StallNone, StallRandom, StallPattern} stall_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_addr_i;
  logic [CfgDataW-1:0]   cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [ZoneIdxW-1:0]   zone_index_i;
  logic [SampleW-1:0]    sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            zone_event_o;
  logic [ZoneIdxW-1:0]   event_zone_o;
  logic [SampleW-1:0]    reading_o;
  logic [AreaOutW-1:0]   areas_triggered_o;
  logic [AreaOutW-1:0]   areas_tampered_o;

  alarm_zone_loop_supervisor uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .zone_index_i      (zone_index_i),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .zone_event_o      (zone_event_o),
    .event_zone_o      (event_zone_o),
    .reading_o         (reading_o),
    .areas_triggered_o (areas_triggered_o),
    .areas_tampered_o  (areas_tampered_o)
  );

  // register shadow, reset values
  logic [SampleW-1:0]  nl_q      = '0;
  logic [SampleW-1:0]  tl_q      = '0;
  logic [SampleW-1:0]  tol_q     = '0;
  logic [BounceW-1:0]  reload_q  = BounceReloadRst;
  logic [MaskW-1:0]    open_q    = '0;
  logic [MaskW-1:0]    skip_q    = '0;
  logic [CfgDataW-1:0] amap_q    = '0;

  // supervision state
  logic [MaskW-1:0]    zone_trig = '0;
  logic [MaskW-1:0]    zone_tamp = '0;
  logic [BounceW-1:0]  bounce_cnt [DefZones];
  logic [AreaOutW-1:0] area_trig = '0;
  logic [AreaOutW-1:0] area_tamp = '0;

  loop_sample_t  pending_q [$];
  azls_res_t     zone_report_q [$];
  loop_sample_t  drv_item;
  azls_res_t     want;

  int          errors       = 0;
  int          queued_cnt   = 0;
  int          results_seen = 0;
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          gap_max      = 0;
  int          hold_left    = 0;
  int          pattern_cnt  = 0;
  bit          hold_done    = 1'b0;
  bit          in_taken     = 1'b0;
  stall_mode_e stall_mode   = StallNone;

  initial begin
    for (int i = 0; i < DefZones; i++) bounce_cnt[i] = '0;
  end

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("** alarm_zone_loop_supervisor: FAILED **");
    $finish;
  end

  function automatic bit in_win(logic [SampleW-1:0] v, logic [SampleW-1:0] c);
    int unsigned lo, hi;
    lo = (c > tol_q) ? 32'(c) - 32'(tol_q) : 32'd0;
    hi = 32'(c) + 32'(tol_q);
    if (hi > 1023) hi = 1023;
    return (32'(v) >= lo) && (32'(v) <= hi);
  endfunction

  function automatic logic [AreaOutW-1:0] areas_of_zone(logic [ZoneIdxW-1:0] z);
    logic [AreaOutW-1:0] m;
    m = '0;
    for (int a = 0; a < DefAreas; a++) m[a] = amap_q[a*ZoneStride + int'(z)];
    return m;
  endfunction

  // member areas of zone z where no other member zone holds a flag in vec
  function automatic logic [AreaOutW-1:0] areas_free_of(logic [ZoneIdxW-1:0] z,
                                                        logic [MaskW-1:0] vec);
    logic [AreaOutW-1:0] clr;
    bit busy;
    clr = '0;
    for (int a = 0; a < DefAreas; a++) begin
      if (amap_q[a*ZoneStride + int'(z)]) begin
        busy = 1'b0;
        for (int o = 0; o < DefZones; o++)
          if (o != int'(z) && amap_q[a*ZoneStride + o] && vec[o]) busy = 1'b1;
        if (!busy) clr[a] = 1'b1;
      end
    end
    return clr;
  endfunction

  function automatic azls_res_t next_zone_report(logic [ZoneIdxW-1:0] z,
                                                 logic [SampleW-1:0] v);
    azls_res_t   r;
    zone_event_e cur, prev, ev;
    logic        is_open;
    ev = EvNothing;
    is_open = open_q[z];
    if (!skip_q[z]) begin
      if (in_win(v, nl_q)) cur = is_open ? EvTrigger : EvNormal;
      else if (in_win(v, tl_q)) cur = is_open ? EvNormal : EvTrigger;
      else cur = EvTamper;

      if (zone_tamp[z]) prev = EvTamper;
      else if (zone_trig[z]) prev = EvTrigger;
      else prev = EvNormal;

      if (prev == cur && bounce_cnt[z] == 0) begin
        ev = EvNothing;
      end else if (cur == EvTamper) begin
        zone_tamp[z] = 1'b1;
        bounce_cnt[z] = '0;
        area_tamp |= areas_of_zone(z);
        ev = EvTamper;
      end else if (prev == EvTamper) begin
        // back from tamper: triggered flag goes too, area trigger flags stay
        zone_tamp[z] = 1'b0;
        bounce_cnt[z] = '0;
        area_tamp &= ~areas_free_of(z, zone_tamp);
        zone_trig[z] = 1'b0;
        ev = EvNormal;
      end else if (bounce_cnt[z] > 1) begin
        bounce_cnt[z] = (cur == EvTrigger) ? '0 : BounceW'(bounce_cnt[z] - 1);
      end else if (bounce_cnt[z] == 1) begin
        bounce_cnt[z] = '0;
        if (cur != EvTrigger) begin
          zone_trig[z] = 1'b0;
          zone_tamp[z] = 1'b0;
          area_trig &= ~areas_free_of(z, zone_trig);
          ev = EvNormal;
        end
      end else if (cur == EvNormal) begin
        bounce_cnt[z] = (reload_q != 0) ? reload_q : BounceW'(1);
      end else begin
        bounce_cnt[z] = '0;
        zone_trig[z] = 1'b1;
        area_trig |= areas_of_zone(z);
        ev = EvTrigger;
      end
    end
    r.ev        = ev;
    r.zone      = z;
    r.reading   = v;
    r.area_trig = area_trig;
    r.area_tamp = area_tamp;
    return r;
  endfunction

  function void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // a loop reading that zone z should see as the wanted state
  function automatic logic [SampleW-1:0] reading_for(logic [ZoneIdxW-1:0] z,
                                                    zone_event_e kind);
    int unsigned c, lo, hi;
    logic [SampleW-1:0] v;
    if (kind == EvTamper) begin
      v = SampleW'($urandom_range(1023, 0));
      for (int i = 0; i < 16 && (in_win(v, nl_q) || in_win(v, tl_q)); i++)
        v = SampleW'($urandom_range(1023, 0));
      return v;
    end
    c = (open_q[z] ^ (kind == EvTrigger)) ? 32'(tl_q) : 32'(nl_q);
    lo = (c > 32'(tol_q)) ? c - 32'(tol_q) : 32'd0;
    hi = (c + 32'(tol_q) > 1023) ? 32'd1023 : c + 32'(tol_q);
    return SampleW'($urandom_range(hi, lo));
  endfunction

  function void push_item(logic [ZoneIdxW-1:0] z, logic [SampleW-1:0] v);
    loop_sample_t s;
    s.zone = z;
    s.smp = v;
    pending_q.push_back(s);
    if (!skip_q[z]) queued_cnt++;
  endfunction

  // trigger, then a run of normal readings that is only sometimes long enough to clear
  task automatic queue_zone_run();
    logic [ZoneIdxW-1:0] z;
    int unsigned eff, steps;
    z = ZoneIdxW'($urandom_range(15, 0));
    eff = (reload_q == 0) ? 32'd1 : 32'(reload_q);
    if (eff > 6) eff = 6;
    push_item(z, reading_for(z, EvTrigger));
    steps = $urandom_range(eff + 1, 0);
    repeat (steps) push_item(z, reading_for(z, EvNormal));
    if ($urandom_range(3, 0) == 0) begin
      push_item(z, reading_for(z, EvTamper));
      push_item(z, reading_for(z, EvNormal));
    end
  endtask

  task automatic run_random(int n);
    int target;
    logic [ZoneIdxW-1:0] z;
    zone_event_e kind;
    target = queued_cnt + n;
    while (queued_cnt < target) begin
      if ($urandom_range(9, 0) < 7) begin
        queue_zone_run();
      end else begin
        z = ZoneIdxW'($urandom_range(15, 0));
        kind = zone_event_e'($urandom_range(3, 1));
        push_item(z, $urandom_range(1, 0) ? 10'($urandom_range(1023, 0)) : reading_for(z, kind));
      end
    end
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgNormalLevel:  nl_q     = data[SampleW-1:0];
      CfgTriggerLevel: tl_q     = data[SampleW-1:0];
      CfgTolerance:    tol_q    = data[SampleW-1:0];
      CfgBounceReload: reload_q = data[BounceW-1:0];
      CfgOpenMask:     open_q   = data[MaskW-1:0];
      CfgSkipMask:     skip_q   = data[MaskW-1:0];
      CfgAreaMap:      amap_q   = data;
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned nl, int unsigned tl, int unsigned tol,
                            int unsigned reload, logic [MaskW-1:0] open_m,
                            logic [MaskW-1:0] skip_m, logic [CfgDataW-1:0] amap);
    cfg_write(CfgNormalLevel, CfgDataW'(nl));
    cfg_write(CfgTriggerLevel, CfgDataW'(tl));
    cfg_write(CfgTolerance, CfgDataW'(tol));
    cfg_write(CfgBounceReload, CfgDataW'(reload));
    cfg_write(CfgOpenMask, CfgDataW'(open_m));
    cfg_write(CfgSkipMask, CfgDataW'(skip_m));
    cfg_write(CfgAreaMap, amap);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid_i || zone_report_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // input side: note each transfer and predict its report
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) zone_report_q.push_back(next_zone_report(zone_index_i, sample_i));
  end

  // sender: bursts with random gaps, payload held while stalled
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pending_q.size() != 0) begin
        drv_item = pending_q.pop_front();
        zone_index_i <= drv_item.zone;
        sample_i     <= drv_item.smp;
        in_valid_i   <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(12, 1);
          gap_left = (gap_max > 0) ? $urandom_range(gap_max, 1) : 0;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall; one long hold-off partway through to back the block up
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_seen >= 250) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        StallRandom:  out_stall_i <= ($urandom_range(2, 0) == 0);
        StallPattern: out_stall_i <= ((pattern_cnt % 7) < 3);
        default:      out_stall_i <= 1'b0;
      endcase
    end
    pattern_cnt++;
  end

  // output side: compare each transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (zone_report_q.size() == 0) begin
        $error("unexpected report: zone %0d event %0d", event_zone_o, zone_event_o);
        errors++;
      end else begin
        want = zone_report_q.pop_front();
        check_field("zone_event", 32'(want.ev), 32'(zone_event_o));
        check_field("event_zone", 32'(want.zone), 32'(event_zone_o));
        check_field("reading", 32'(want.reading), 32'(reading_o));
        check_field("areas_triggered", 32'(want.area_trig), 32'(areas_triggered_o));
        check_field("areas_tampered", 32'(want.area_tamp), 32'(areas_tampered_o));
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_addr_i   = CfgNormalLevel;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    zone_index_i = '0;
    sample_i     = '0;
    out_stall_i  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // register reset values: both windows collapse onto zero
    push_item(4'd0, 10'd0);
    push_item(4'd0, 10'd512);
    push_item(4'd0, 10'd0);
    wait_idle();

    // directed: areas 0 {z0,z1}, 1 {z0}, 2 {z3}, 3 {z15}; z3 normally open, z5 skipped
    set_config(200, 600, 50, 2, 16'h0008, 16'h0020, 64'h8000_0008_0001_0003);
    push_item(4'd0, 10'd600);
    push_item(4'd1, 10'd610);
    push_item(4'd0, 10'd200);
    push_item(4'd0, 10'd150);
    push_item(4'd0, 10'd250);   // area 0 kept, zone 1 still triggered
    push_item(4'd1, 10'd200);
    push_item(4'd1, 10'd200);
    push_item(4'd1, 10'd200);
    push_item(4'd0, 10'd650);
    push_item(4'd0, 10'd200);
    push_item(4'd0, 10'd600);   // trigger during countdown cancels it
    push_item(4'd0, 10'd1023);
    push_item(4'd0, 10'd0);
    push_item(4'd0, 10'd200);   // back from tamper
    push_item(4'd3, 10'd200);
    push_item(4'd3, 10'd600);
    push_item(4'd5, 10'd1023);
    push_item(4'd15, 10'd0);
    push_item(4'd15, 10'd1023);
    push_item(4'd15, 10'd400);
    push_item(4'd15, 10'd600);
    push_item(4'd4, 10'd149);
    push_item(4'd4, 10'd251);
    push_item(4'd4, 10'd550);
    wait_idle();

    // windows saturating at both ends, zero reload, every zone in every area
    stall_mode = StallRandom;
    gap_max = 4;
    set_config(5, 1020, 40, 0, MaskW'($urandom), 16'h0000, '1);
    push_item(4'd2, 10'd0);
    push_item(4'd2, 10'd1023);
    run_random(60);
    wait_idle();

    for (int r = 0; r < 5; r++) begin
      int unsigned nl, tl, tol;
      stall_mode = stall_mode_e'(r % 3);
      gap_max = (r == 2) ? 0 : $urandom_range(8, 1);
      nl = $urandom_range(1023, 0);
      tl = (r == 1) ? nl : $urandom_range(1023, 0);   // overlap: normal wins
      tol = $urandom_range(120, 0);
      if (r == 3) begin
        nl = 0;
        tl = 1023;
        tol = 0;
      end
      set_config(nl, tl, tol, $urandom_range(4, 1), MaskW'($urandom),
                 MaskW'($urandom & $urandom & $urandom), {$urandom, $urandom});
      run_random(100);
      wait_idle();
    end

    // widest window: every reading lands in the normal window
    stall_mode = StallNone;
    gap_max = 0;
    set_config(1023, 0, 1023, 65535, 16'hFFFF, 16'h0000, '1);
    run_random(30);
    wait_idle();

    // all zones skipped
    stall_mode = StallPattern;
    set_config(300, 700, 20, 1, 16'h0000, 16'hFFFF, '0);
    repeat (8) push_item(ZoneIdxW'($urandom_range(15, 0)), SampleW'($urandom_range(1023, 0)));
    wait_idle();

    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("** alarm_zone_loop_supervisor: PASSED **");
    end else begin
      $display("** alarm_zone_loop_supervisor: FAILED **");
    end
    $finish;
  end

endmodule
